/* rtl/ecdf_pkg.sv */
// Package for the empirical CDF engine: sequencer states, function codes,
// default sizes and fixed word field widths. No dependencies.
`timescale 1ns / 1ps

package ecdf_pkg;

	localparam int DEPTH_DEF       = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed widths of the word fields
	localparam int FUNC_W  = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int FRAC_W  = 17;
	localparam int FRAC_SHIFT = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SRCH_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

/* rtl/ecdf_in_if.sv */
// Input channel of the empirical CDF engine: function code and value.
// Depends on ecdf_pkg.
`timescale 1ns / 1ps

interface ecdf_in_if import ecdf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [VALUE_W-1:0] value;

	modport source (output valid, func, value, input ready);
	modport sink (input valid, func, value, output ready);
endinterface

/* rtl/ecdf_out_if.sv */
// Result channel of the empirical CDF engine: count, fraction, overflow.
// Depends on ecdf_pkg.
`timescale 1ns / 1ps

interface ecdf_out_if import ecdf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] count_le;
	logic [FRAC_W-1:0]  fraction;
	logic               overflow;

	modport source (output valid, count_le, fraction, overflow, input ready);
	modport sink (input valid, count_le, fraction, overflow, output ready);
endinterface

/* rtl/empirical_cdf_engine_core.sv */
// Empirical CDF engine: sorted store of reference values with ordered insert,
// upper-bound query and fraction. Depends on ecdf_pkg, ecdf_in_if,
// ecdf_out_if and ecdf_ram.
//
// Usage:
//   req carries one word per item: func (load, query, clear) and a signed
//   Q16.16 value. rsp returns exactly one word per item: count_le, fraction
//   and overflow. The block takes one item at a time; req.ready is high only
//   while the sequencer is idle, also while a finished result waits on rsp.
// Sequence from accept to result:
//   clear, unused code, load into a full store: straight to the done state.
//   query: a binary search over the n stored values, each probe a search
//   state and then a compare state over the RAM's registered read, then a
//   restoring divider yields one quotient bit per cycle.
//   load: the same binary search finds the insert position p; every
//   entry above p moves up one place, a read and then a write per entry
//   through the store's one read port and one write port.
// Reset clears the entry count and the sequencer; store contents are not
// cleared. When rsp stalls, the result is held in the output register and the
// next item may still be taken; its own result waits until rsp drains.
`timescale 1ns / 1ps

module empirical_cdf_engine_core import ecdf_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ecdf_in_if.sink     req,
	ecdf_out_if.source  rsp
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int DW  = CW + FRAC_SHIFT;
	localparam int SW  = $clog2(DW + 1);

	state_t state_q, state_d;

	func_t                        func_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                lo_q, hi_q, mid_q, idx_q;
	logic [CW-1:0]                mid_c;
	logic [DW-1:0]                dvd_q;
	logic [CW-1:0]                rem_q;
	logic [FRAC_W-1:0]            quo_q;
	logic [SW-1:0]                step_q;
	logic [CW:0]                  trial_c;
	logic                         take_c;

	logic                         out_valid_q;
	logic [COUNT_W-1:0]           out_cnt_q;
	logic [FRAC_W-1:0]            out_frac_q;
	logic                         out_ovf_q;
	logic [COUNT_W-1:0]           res_cnt_c;
	logic [FRAC_W-1:0]            res_frac_c;
	logic                         res_ovf_c;
	logic                         out_free_c;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [VALUE_WIDTH-1:0]       ram_wdata, ram_rdata;
	logic [63:0]                  value_ext;

	ecdf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// incoming value: low VALUE_WIDTH bits, sign-extended
	assign value_ext = 64'(signed'(req.value));

	assign mid_c      = lo_q + ((hi_q - lo_q) >> 1);
	assign trial_c    = {rem_q, dvd_q[DW-1]};
	assign take_c     = trial_c >= {1'b0, count_q};
	assign out_free_c = !out_valid_q || rsp.ready;

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.count_le = out_cnt_q;
	assign rsp.fraction = out_frac_q;
	assign rsp.overflow = out_ovf_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					unique case (func_t'(req.func))
						FUNC_LOAD:  state_d = (count_q >= CW'(DEPTH)) ? ST_DONE : ST_SRCH;
						FUNC_QUERY: state_d = (count_q == '0) ? ST_DONE : ST_SRCH;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					state_d = ST_SRCH_CMP;
				end else if (func_q == FUNC_LOAD) begin
					state_d = (count_q > lo_q) ? ST_SH_RD : ST_INS;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_SRCH_CMP: state_d = ST_SRCH;
			ST_SH_RD:    state_d = ST_SH_WR;
			ST_SH_WR:    state_d = (idx_q - CW'(1) > lo_q) ? ST_SH_RD : ST_INS;
			ST_INS:      state_d = ST_DONE;
			ST_DIV:      state_d = (step_q == SW'(1)) ? ST_DONE : ST_DIV;
			ST_DONE:     state_d = out_free_c ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// store port control and result word
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = idx_q[AW-1:0];
		ram_wdata  = ram_rdata;
		ram_raddr  = mid_c[AW-1:0];
		res_cnt_c  = '0;
		res_frac_c = '0;
		res_ovf_c  = 1'b0;
		unique case (state_q)
			ST_SH_RD: ram_raddr = AW'(idx_q - CW'(1));
			ST_SH_WR: ram_we = 1'b1;
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q[AW-1:0];
				ram_wdata = key_q;
			end
			default: ;
		endcase
		case (func_q)
			FUNC_LOAD: begin
				res_cnt_c = COUNT_W'(count_q);
				res_ovf_c = (lo_q == '1);
			end
			FUNC_QUERY: begin
				res_cnt_c  = COUNT_W'(lo_q);
				res_frac_c = quo_q;
			end
			default: ;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req.valid && func_t'(req.func) == FUNC_CLEAR) begin
				count_q <= '0;
			end
			if (state_q == ST_INS) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_DONE && out_free_c) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: search bounds, shift index, divider, result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q <= func_t'(req.func);
				key_q  <= value_ext[VALUE_WIDTH-1:0];
				hi_q   <= count_q;
				idx_q  <= count_q;
				quo_q  <= '0;
				// a full-store load marks overflow through an all-ones lo
				lo_q   <= (func_t'(req.func) == FUNC_LOAD && count_q >= CW'(DEPTH)) ? '1 : '0;
			end
			ST_SRCH: begin
				mid_q <= mid_c;
				dvd_q <= {lo_q, FRAC_SHIFT'(0)};
				rem_q <= '0;
				step_q <= SW'(DW);
			end
			ST_SRCH_CMP: begin
				if ($signed(ram_rdata) <= key_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_SH_WR: idx_q <= idx_q - CW'(1);
			ST_DIV: begin
				dvd_q  <= dvd_q << 1;
				step_q <= step_q - SW'(1);
				rem_q  <= take_c ? CW'(trial_c - {1'b0, count_q}) : CW'(trial_c);
				quo_q  <= {quo_q[FRAC_W-2:0], take_c};
			end
			ST_DONE: begin
				if (out_free_c) begin
					out_cnt_q  <= res_cnt_c;
					out_frac_q <= res_frac_c;
					out_ovf_q  <= res_ovf_c;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/ecdf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ecdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* tb/tb_top.sv */
// Testbench for empirical_cdf_engine_core: drives load, query, clear and unused-code words,
// predicts each result from a sorted-store model and checks it in order.
// Depends on ecdf_pkg, ecdf_in_if, ecdf_out_if and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import ecdf_pkg::*;

	localparam int N_STORE = DEPTH_DEF;

	typedef struct packed {
		logic [COUNT_W-1:0] count_le;
		logic [FRAC_W-1:0]  fraction;
		logic               overflow;
	} cdf_res_t;

	logic clk;
	logic arst_n;
	ecdf_in_if  req();
	ecdf_out_if rsp();

	empirical_cdf_engine_core uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// predictor state: sorted signed values
	logic signed [31:0] ref_vals[$];
	cdf_res_t           pending_res[$];
	int                 err_cnt;
	bit                 rx_hold;      // long receiver hold-off request
	bit                 gap_enable;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int count_not_above(logic signed [31:0] v);
		int lo, hi, mid;
		lo = 0;
		hi = ref_vals.size();
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (ref_vals[mid] <= v) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	// expected result of one word, store updated in place
	function automatic cdf_res_t predict_cdf(func_t f, logic signed [31:0] v);
		cdf_res_t r;
		int p;
		longint q;
		r = '0;
		case (f)
			FUNC_LOAD: begin
				if (ref_vals.size() >= N_STORE) begin
					r.overflow = 1'b1;
				end else begin
					p = count_not_above(v);
					ref_vals.insert(p, v);
				end
				r.count_le = COUNT_W'(ref_vals.size());
			end
			FUNC_QUERY: begin
				if (ref_vals.size() != 0) begin
					p = count_not_above(v);
					q = (longint'(p) << FRAC_SHIFT) / ref_vals.size();
					r.count_le = COUNT_W'(p);
					r.fraction = FRAC_W'(q);
				end
			end
			FUNC_CLEAR: begin
				ref_vals.delete();
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int rand_gap();
		if (!gap_enable) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// send one word, wait for its acceptance; valid drops only in a gap
	task automatic send_word(func_t f, logic [31:0] v);
		int g;
		g = rand_gap();
		if (g != 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.func  <= f;
		req.value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_res.push_back(predict_cdf(f, v));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// receiver ready with random stalls
	initial begin
		int g;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				rsp.ready <= 1'b0;
				repeat (300) @(negedge clk);
				rx_hold = 1'b0;
			end
			g = rand_gap();
			if (g != 0) begin
				rsp.ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// result checker
	initial begin
		cdf_res_t e;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				if (pending_res.size() == 0) begin
					$error("result word with nothing expected");
					err_cnt++;
				end else begin
					e = pending_res.pop_front();
					if (rsp.count_le !== e.count_le) begin
						$error("count_le exp %0d got %0d", e.count_le, rsp.count_le);
						err_cnt++;
					end
					if (rsp.fraction !== e.fraction) begin
						$error("fraction exp %0d got %0d", e.fraction, rsp.fraction);
						err_cnt++;
					end
					if (rsp.overflow !== e.overflow) begin
						$error("overflow exp %0d got %0d", e.overflow, rsp.overflow);
						err_cnt++;
					end
				end
			end
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15) - 8;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// directed: extremes, empty query, clear, unused code, duplicates
	task automatic test_directed();
		send_word(FUNC_QUERY, 32'h0000_0000);
		send_word(FUNC_LOAD, 32'h8000_0000);
		send_word(FUNC_LOAD, 32'h7FFF_FFFF);
		send_word(FUNC_LOAD, 32'h0001_0000);
		send_word(FUNC_LOAD, 32'h0001_0000);
		send_word(FUNC_QUERY, 32'h8000_0000);
		send_word(FUNC_QUERY, 32'h7FFF_FFFF);
		send_word(FUNC_QUERY, 32'h0001_0000);
		send_word(FUNC_QUERY, 32'hFFFF_FFFF);
		send_word(FUNC_NONE, 32'hFFFF_FFFF);
		send_word(FUNC_QUERY, 32'h0000_FFFF);
		send_word(FUNC_CLEAR, 32'hA5A5_5A5A);
		send_word(FUNC_QUERY, 32'h7FFF_FFFF);
		send_word(FUNC_LOAD, 32'h5555_AAAA);
		send_word(FUNC_QUERY, 32'h5555_AAAA);
		send_word(FUNC_CLEAR, 32'h0);
	endtask

	// random mix over small stores; every word gets a result
	task automatic test_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) send_word(FUNC_LOAD, rand_value());
			else if (r < 93) send_word(FUNC_QUERY, rand_value());
			else if (r < 97 || ref_vals.size() < 40) begin
				if (r >= 97) send_word(FUNC_NONE, rand_value());
				else send_word(FUNC_CLEAR, rand_value());
			end else send_word(FUNC_CLEAR, rand_value());
		end
	endtask

	// long receiver stall while words keep coming
	task automatic test_backpressure();
		rx_hold = 1'b1;
		test_random(40);
		wait_drained();
	endtask

	// fill the store to capacity, then overflow loads and queries
	task automatic test_full_store();
		send_word(FUNC_CLEAR, 32'h0);
		gap_enable = 1'b0;
		for (int i = 0; i < N_STORE; i++)
			send_word(FUNC_LOAD, 32'h7FFF_FFF0 - i);
		gap_enable = 1'b1;
		send_word(FUNC_LOAD, 32'h0000_0000);
		send_word(FUNC_LOAD, 32'h8000_0000);
		send_word(FUNC_QUERY, 32'h7FFF_FFFF);
		send_word(FUNC_QUERY, 32'h7FFF_FBFE);
		send_word(FUNC_QUERY, 32'h8000_0000);
		send_word(FUNC_CLEAR, 32'h0);
		wait_drained();
	endtask

	initial begin
		err_cnt    = 0;
		rx_hold    = 1'b0;
		gap_enable = 1'b1;
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.func   = FUNC_LOAD;
		req.value  = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		test_random(100);
		wait_drained();
		test_backpressure();
		test_random(60);
		test_full_store();
		wait_drained();
		if (err_cnt == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ecdf_pkg.sv
rtl/ecdf_in_if.sv
rtl/ecdf_out_if.sv
rtl/ecdf_ram.sv
rtl/empirical_cdf_engine_core.sv
tb/tb_top.sv
